@@ src/assert_macros.svh @@
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Check a consequent in the same cycle as its antecedent.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/ldc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package ldc_pkg;

  localparam int FIELD_WIDTH = 32;
  localparam int INDEX_WIDTH = 6;
  localparam int CFG_WIDTH   = 7;

  localparam logic [CFG_WIDTH-1:0] MIN_LEN_RESET = 7'd6;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_SHORT = 1'b1;

  typedef struct packed {
    logic signed [FIELD_WIDTH-1:0] flow_value;
    logic signed [FIELD_WIDTH-1:0] pressure_drop;
    logic                          last_item;
  } point_t;

  typedef struct packed {
    logic [INDEX_WIDTH-1:0]        point_index;
    logic signed [FIELD_WIDTH-1:0] out_flow;
    logic signed [FIELD_WIDTH-1:0] out_pressure;
    logic                          status;
    logic                          overflowed;
    logic                          last_result;
  } result_t;

endpackage

`default_nettype wire

@@ src/ldc_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ldc_ram #(
  parameter int WIDTH = 72,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // hold read data until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ src/longest_dominated_chain.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Handshake                   Payload
// point    in         point_valid / point_stall   ldc_pkg::point_t
// result   out        result_valid / result_stall ldc_pkg::result_t
// cfg      in         cfg_write                   cfg_data (min_chain_length)
//
// A point stored at index i > 0 passes through one table read per earlier
// point, a compare step, a drain step, a write-back and an idle step;
// a point stored at index 0 needs no read or compare, a dropped point only idle.
// After the last point: a finish step, then per emitted result a table read
// and a load of the output register, the load waiting while result_stall holds.
// Reset is synchronous, no clearing pass; point_stall is low only when idle.

module longest_dominated_chain #(
  parameter int MAX_POINTS  = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                point_valid,
  output logic                                point_stall,
  input  ldc_pkg::point_t                     point,
  output logic                                result_valid,
  input  logic                                result_stall,
  output ldc_pkg::result_t                    result,
  input  logic                                cfg_write,
  input  logic [ldc_pkg::CFG_WIDTH-1:0]       cfg_data
);

  import ldc_pkg::*;

  `include "assert_macros.svh"

  localparam int SW = (VALUE_WIDTH < FIELD_WIDTH) ? VALUE_WIDTH : FIELD_WIDTH;
  localparam int IW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int LW = $clog2(MAX_POINTS + 1);
  localparam int EW = 2 * SW + LW + IW + 1;

  localparam int HP_LO   = 0;
  localparam int PRED_LO = HP_LO + 1;
  localparam int LEN_LO  = PRED_LO + IW;
  localparam int P_LO    = LEN_LO + LW;
  localparam int F_LO    = P_LO + SW;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_WRITE,
    S_FINISH,
    S_SHORT,
    S_EMIT_RD,
    S_EMIT_LD
  } state_t;

  state_t state;

  logic [CW-1:0]        item_count;
  logic [LW-1:0]        best_len;
  logic [IW-1:0]        best_end;
  logic                 drop;
  logic [CFG_WIDTH-1:0] min_len;

  logic signed [SW-1:0] cur_f;
  logic signed [SW-1:0] cur_p;
  logic                 cur_last;
  logic [CW-1:0]        j;
  logic                 pend;
  logic [IW-1:0]        rd_idx;
  logic [LW-1:0]        run_len;
  logic [IW-1:0]        run_pred;
  logic                 run_hp;
  logic [IW-1:0]        cur;

  logic                 mem_we;
  logic                 mem_re;
  logic [IW-1:0]        mem_raddr;
  logic [EW-1:0]        mem_wdata;
  logic [EW-1:0]        rd_data;

  logic signed [SW-1:0] rd_f;
  logic signed [SW-1:0] rd_p;
  logic [LW-1:0]        rd_len;
  logic [IW-1:0]        rd_pred;
  logic                 rd_hp;
  logic [LW:0]          rd_len_inc;
  logic                 issue;
  logic                 hit;
  logic                 slot_free;
  logic                 load_out;
  logic                 emit_link;
  logic                 short_out;
  logic                 set_close;

  assign rd_f       = rd_data[F_LO +: SW];
  assign rd_p       = rd_data[P_LO +: SW];
  assign rd_len     = rd_data[LEN_LO +: LW];
  assign rd_pred    = rd_data[PRED_LO +: IW];
  assign rd_hp      = rd_data[HP_LO];
  assign rd_len_inc = {1'b0, rd_len} + (LW + 1)'(1);

  assign issue     = (state == S_SCAN) && (j < item_count);
  assign hit       = pend && (cur_f < rd_f) && (cur_p < rd_p) && ({1'b0, run_len} < rd_len_inc);
  assign slot_free = !result_valid || !result_stall;
  assign load_out  = slot_free && ((state == S_SHORT) || (state == S_EMIT_LD));
  assign emit_link = (state == S_EMIT_LD) && rd_hp;
  assign short_out = result_valid && (result.status == STATUS_SHORT);
  assign set_close = load_out && ((state == S_SHORT) || !rd_hp);

  assign point_stall = (state != S_IDLE);

  assign mem_we    = (state == S_WRITE);
  assign mem_re    = issue || (state == S_EMIT_RD);
  assign mem_raddr = (state == S_EMIT_RD) ? cur : j[IW-1:0];
  assign mem_wdata = {cur_f, cur_p, run_len, run_pred, run_hp};

  ldc_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_POINTS)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (item_count[IW-1:0]),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      item_count   <= '0;
      best_len     <= LW'(1);
      best_end     <= '0;
      drop         <= 1'b0;
      min_len      <= MIN_LEN_RESET;
      result_valid <= 1'b0;
      pend         <= 1'b0;
    end else begin
      if (cfg_write) begin
        min_len <= cfg_data;
      end
      if (load_out) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (point_valid) begin
            cur_f    <= SW'(point.flow_value);
            cur_p    <= SW'(point.pressure_drop);
            cur_last <= point.last_item;
            if (item_count < CW'(MAX_POINTS)) begin
              j        <= '0;
              pend     <= 1'b0;
              run_len  <= LW'(1);
              run_pred <= '0;
              run_hp   <= 1'b0;
              state    <= S_SCAN;
            end else begin
              drop <= 1'b1;
              if (point.last_item) begin
                state <= S_FINISH;
              end
            end
          end
        end
        S_SCAN: begin
          pend <= issue;
          if (issue) begin
            j      <= j + CW'(1);
            rd_idx <= j[IW-1:0];
          end
          if (hit) begin
            run_len  <= LW'(rd_len_inc);
            run_pred <= rd_idx;
            run_hp   <= 1'b1;
          end
          if (!issue && !pend) begin
            state <= S_WRITE;
          end
        end
        S_WRITE: begin
          if (best_len < run_len) begin
            best_len <= run_len;
            best_end <= item_count[IW-1:0];
          end
          item_count <= item_count + CW'(1);
          state      <= cur_last ? S_FINISH : S_IDLE;
        end
        S_FINISH: begin
          if (CFG_WIDTH'(best_len) < min_len) begin
            state <= S_SHORT;
          end else begin
            cur   <= best_end;
            state <= S_EMIT_RD;
          end
        end
        S_SHORT: begin
          if (slot_free) begin
            result.point_index  <= '0;
            result.out_flow     <= '0;
            result.out_pressure <= '0;
            result.status       <= STATUS_SHORT;
            result.overflowed   <= drop;
            result.last_result  <= 1'b1;
            item_count          <= '0;
            best_len            <= LW'(1);
            best_end            <= '0;
            drop                <= 1'b0;
            state               <= S_IDLE;
          end
        end
        S_EMIT_RD: begin
          state <= S_EMIT_LD;
        end
        S_EMIT_LD: begin
          if (slot_free) begin
            result.point_index  <= INDEX_WIDTH'(cur);
            result.out_flow     <= FIELD_WIDTH'(rd_f);
            result.out_pressure <= FIELD_WIDTH'(rd_p);
            result.status       <= STATUS_OK;
            result.overflowed   <= drop;
            result.last_result  <= !rd_hp;
            if (rd_hp) begin
              cur   <= rd_pred;
              state <= S_EMIT_RD;
            end else begin
              item_count <= '0;
              best_len   <= LW'(1);
              best_end   <= '0;
              drop       <= 1'b0;
              state      <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `ASSERT_ALWAYS(a_scan_bound, clk, rst, state != S_SCAN || j <= item_count, "scan past fill")
  `ASSERT_IMPL(a_pred_order, clk, rst, emit_link, rd_pred < cur, "predecessor not older")
  `ASSERT_IMPL(a_short_last, clk, rst, short_out, result.last_result, "short result not last")
  `ASSERT_NEXT(a_set_end, clk, rst, set_close, state == S_IDLE && item_count == '0, "set not closed")

endmodule

`default_nettype wire

@@ sim/longest_dominated_chain_test.sv @@
`timescale 1ns / 1ps

module longest_dominated_chain_test;
  import ldc_pkg::*;

  localparam int CLK_PERIOD     = 12;
  localparam int DEPTH          = 64;
  localparam int GAP_MAX        = 18;
  localparam int SETTLE         = 20;
  localparam int HOLD_CYCLES    = 600;
  localparam int TOTAL_POINTS   = 200;
  localparam int TIMEOUT_CYCLES = 2000000;
  localparam int NO_CFG         = -1;
  localparam logic signed [FIELD_WIDTH-1:0] F_MAX = 32'sh7fffffff;
  localparam logic signed [FIELD_WIDTH-1:0] F_MIN = 32'sh80000000;

  logic                 clk          = 1'b0;
  logic                 rst          = 1'b1;
  logic                 point_valid  = 1'b0;
  logic                 point_stall;
  point_t               point        = '0;
  logic                 result_valid;
  logic                 result_stall = 1'b0;
  result_t              result;
  logic                 cfg_write    = 1'b0;
  logic [CFG_WIDTH-1:0] cfg_data     = MIN_LEN_RESET;

  longest_dominated_chain #(
    .MAX_POINTS(DEPTH),
    .VALUE_WIDTH(FIELD_WIDTH)
  ) uut (
    .clk(clk),
    .rst(rst),
    .point_valid(point_valid),
    .point_stall(point_stall),
    .point(point),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result),
    .cfg_write(cfg_write),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Predictor copy of the point table and set state
  logic signed [FIELD_WIDTH-1:0] flow_mem   [DEPTH];
  logic signed [FIELD_WIDTH-1:0] pres_mem   [DEPTH];
  int                            chain_mem  [DEPTH];
  logic [INDEX_WIDTH-1:0]        link_mem   [DEPTH];
  bit                            linked_mem [DEPTH];
  int stored   = 0;
  int best_len = 1;
  int best_end = 0;
  bit dropped  = 1'b0;
  int min_len  = int'(MIN_LEN_RESET);

  result_t chain_out [$];
  result_t pending   [$];

  int errors       = 0;
  int checked      = 0;
  int sent_points  = 0;
  int settings     = 0;
  int hold_request = 0;
  int rx_left      = 0;
  bit tx_quiet     = 1'b0;
  bit rx_quiet     = 1'b0;

  function automatic void predict_point(input point_t p);
    logic signed [FIELD_WIDTH-1:0] f;
    logic signed [FIELD_WIDTH-1:0] q;
    int      len;
    int      link;
    bit      linked;
    int      cur;
    bit      more;
    result_t r;
    chain_out.delete();
    f = p.flow_value;
    q = p.pressure_drop;
    if (stored < DEPTH) begin
      len = 1;
      link = 0;
      linked = 1'b0;
      for (int j = 0; j < stored; j++) begin
        if (f < flow_mem[j] && q < pres_mem[j] && len < chain_mem[j] + 1) begin
          len = chain_mem[j] + 1;
          link = j;
          linked = 1'b1;
        end
      end
      flow_mem[stored] = f;
      pres_mem[stored] = q;
      chain_mem[stored] = len;
      link_mem[stored] = link[INDEX_WIDTH-1:0];
      linked_mem[stored] = linked;
      if (best_len < len) begin
        best_len = len;
        best_end = stored;
      end
      stored++;
    end else begin
      dropped = 1'b1;
    end
    if (!p.last_item) return;
    if (best_len < min_len) begin
      r = '0;
      r.status = STATUS_SHORT;
      r.overflowed = dropped;
      r.last_result = 1'b1;
      chain_out = {chain_out, r};
    end else begin
      cur = best_end;
      more = 1'b1;
      while (more && chain_out.size() < DEPTH) begin
        r.point_index = cur[INDEX_WIDTH-1:0];
        r.out_flow = flow_mem[cur];
        r.out_pressure = pres_mem[cur];
        r.status = STATUS_OK;
        r.overflowed = dropped;
        r.last_result = 1'b0;
        chain_out = {chain_out, r};
        more = linked_mem[cur];
        cur = int'(link_mem[cur]);
      end
      r = chain_out.pop_back();
      r.last_result = 1'b1;
      chain_out = {chain_out, r};
    end
    stored = 0;
    best_len = 1;
    best_end = 0;
    dropped = 1'b0;
  endfunction

  function automatic point_t make_point(input logic signed [FIELD_WIDTH-1:0] f,
                                        input logic signed [FIELD_WIDTH-1:0] q,
                                        input logic last);
    point_t p;
    p.flow_value = f;
    p.pressure_drop = q;
    p.last_item = last;
    return p;
  endfunction

  function automatic result_t lone_result(input logic signed [FIELD_WIDTH-1:0] f,
                                          input logic signed [FIELD_WIDTH-1:0] q);
    result_t r;
    r = '0;
    r.out_flow = f;
    r.out_pressure = q;
    r.status = STATUS_OK;
    r.last_result = 1'b1;
    return r;
  endfunction

  function automatic result_t short_result();
    result_t r;
    r = '0;
    r.status = STATUS_SHORT;
    r.last_result = 1'b1;
    return r;
  endfunction

  function automatic logic signed [FIELD_WIDTH-1:0] step_down(
      input logic signed [FIELD_WIDTH-1:0] v);
    longint nv;
    nv = longint'(v) - longint'($urandom_range(1, 1 << 20));
    if (nv < longint'(F_MIN)) return $signed($urandom());
    return nv[FIELD_WIDTH-1:0];
  endfunction

  // Valid stays high on return; the caller sends again or drains in the same step.
  task automatic send_point(input point_t p, input bit typed, input result_t want);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, GAP_MAX);
    if (gap > 0) begin
      point_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    point_valid <= 1'b1;
    point <= p;
    @(posedge clk);
    while (point_stall) @(posedge clk);
    predict_point(p);
    if (typed) begin
      pending = {pending, want};
    end else begin
      foreach (chain_out[k]) pending = {pending, chain_out[k]};
    end
    sent_points++;
  endtask

  task automatic drain();
    point_valid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_min(input int v);
    drain();
    cfg_write <= 1'b1;
    cfg_data <= v[CFG_WIDTH-1:0];
    @(posedge clk);
    cfg_write <= 1'b0;
    min_len = v;
    settings++;
  endtask

  task automatic random_set(input int n, input int decline_pct);
    logic signed [FIELD_WIDTH-1:0] f;
    logic signed [FIELD_WIDTH-1:0] q;
    int pick;
    tx_quiet = ($urandom_range(0, 3) == 0);
    rx_quiet = ($urandom_range(0, 3) == 0);
    f = $urandom();
    q = $urandom();
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(1, 100);
      if (pick <= decline_pct) begin
        f = step_down(f);
        q = step_down(q);
      end else if (pick <= decline_pct + 10) begin
        q = step_down(q);
      end else begin
        f = $urandom();
        q = $urandom();
      end
      send_point(make_point(f, q, k == n - 1), 1'b0, '0);
    end
  endtask

  typedef struct {
    int      cfg;
    point_t  req;
    bit      typed;
    result_t want;
  } row_t;

  row_t rows [$];

  function automatic void add_row(input int cfg,
                                  input logic signed [FIELD_WIDTH-1:0] f,
                                  input logic signed [FIELD_WIDTH-1:0] q,
                                  input logic last, input bit typed, input result_t want);
    row_t r;
    r.cfg = cfg;
    r.req = make_point(f, q, last);
    r.typed = typed;
    r.want = want;
    rows = {rows, r};
  endfunction

  // Receiver: random stall per result, plus the long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      rx_left = 0;
    end else begin
      if (result_valid && !result_stall) begin
        rx_left = rx_quiet ? 0 : $urandom_range(0, GAP_MAX);
      end else if (!result_valid && rx_left == 0 && !rx_quiet &&
                   $urandom_range(0, 7) == 0) begin
        rx_left = $urandom_range(1, GAP_MAX);
      end
      if (hold_request != 0) begin
        rx_left = hold_request;
        hold_request = 0;
      end
      if (rx_left != 0) begin
        result_stall <= 1'b1;
        rx_left--;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending.size() == 0) begin
        $error("result with none expected: point_index %0d", result.point_index);
        errors++;
      end else begin
        want = pending.pop_front();
        checked++;
        if (result.point_index !== want.point_index) begin
          $error("point_index: expected %0d, got %0d", want.point_index, result.point_index);
          errors++;
        end
        if (result.out_flow !== want.out_flow) begin
          $error("out_flow: expected %0d, got %0d", want.out_flow, result.out_flow);
          errors++;
        end
        if (result.out_pressure !== want.out_pressure) begin
          $error("out_pressure: expected %0d, got %0d", want.out_pressure, result.out_pressure);
          errors++;
        end
        if (result.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, result.status);
          errors++;
        end
        if (result.overflowed !== want.overflowed) begin
          $error("overflowed: expected %0d, got %0d", want.overflowed, result.overflowed);
          errors++;
        end
        if (result.last_result !== want.last_result) begin
          $error("last_result: expected %0d, got %0d", want.last_result, result.last_result);
          errors++;
        end
      end
    end
  end

  initial begin
    int choice;
    int v;
    add_row(NO_CFG, 0, 0, 1'b1, 1'b1, short_result());
    add_row(NO_CFG, F_MAX, F_MAX, 1'b0, 1'b0, '0);
    add_row(NO_CFG, F_MIN, F_MIN, 1'b1, 1'b1, short_result());
    add_row(1, F_MIN, F_MAX, 1'b1, 1'b1, lone_result(F_MIN, F_MAX));
    add_row(NO_CFG, 100, 100, 1'b0, 1'b0, '0);
    add_row(NO_CFG, 50, 50, 1'b0, 1'b0, '0);
    add_row(NO_CFG, 0, 0, 1'b0, 1'b0, '0);
    add_row(NO_CFG, -50, -50, 1'b0, 1'b0, '0);
    add_row(NO_CFG, F_MIN, F_MIN, 1'b1, 1'b0, '0);
    add_row(NO_CFG, 7, 7, 1'b0, 1'b0, '0);
    add_row(NO_CFG, 7, 7, 1'b0, 1'b0, '0);
    add_row(NO_CFG, 7, 6, 1'b1, 1'b1, lone_result(7, 7));
    add_row(NO_CFG, 10, 0, 1'b0, 1'b0, '0);
    add_row(NO_CFG, 5, 5, 1'b0, 1'b0, '0);
    add_row(NO_CFG, 0, -1, 1'b0, 1'b0, '0);
    add_row(NO_CFG, 20, -20, 1'b0, 1'b0, '0);
    add_row(NO_CFG, -3, -30, 1'b0, 1'b0, '0);
    add_row(NO_CFG, -4, -2, 1'b1, 1'b0, '0);
    add_row(0, 1, 1, 1'b1, 1'b1, lone_result(1, 1));
    add_row(127, 3, 3, 1'b0, 1'b0, '0);
    add_row(NO_CFG, 2, 2, 1'b1, 1'b1, short_result());

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (rows[i]) begin
      if (rows[i].cfg != NO_CFG) set_min(rows[i].cfg);
      send_point(rows[i].req, rows[i].typed, rows[i].want);
    end

    set_min(1);
    repeat (4) random_set($urandom_range(1, 10), $urandom_range(40, 100));

    // Hold the result side while the next set keeps offering points
    set_min(3);
    hold_request = HOLD_CYCLES;
    tx_quiet = 1'b1;
    rx_quiet = 1'b0;
    for (int k = 0; k < 8; k++) begin
      send_point(make_point(F_MAX - k * 1000, 1000 - k * 7, k == 3 || k == 7), 1'b0, '0);
    end

    // Fill past capacity with one long falling chain
    set_min(64);
    tx_quiet = 1'b0;
    for (int k = 0; k < DEPTH + 2; k++) begin
      send_point(make_point(F_MAX - k * 977, 32'sd5000 - k * 3, k == DEPTH + 1), 1'b0, '0);
    end

    while (sent_points < TOTAL_POINTS) begin
      choice = $urandom_range(0, 7);
      case (choice)
        0: v = 0;
        1: v = 1;
        2: v = 64;
        3: v = 65;
        4: v = 127;
        default: v = $urandom_range(1, 8);
      endcase
      set_min(v);
      repeat ($urandom_range(2, 4)) begin
        random_set($urandom_range(1, 12), $urandom_range(40, 100));
        if ($urandom_range(0, 3) == 0) drain();
      end
    end

    drain();
    $display("Covered %0d points under %0d minimum-length settings, %0d results checked",
             sent_points, settings, checked);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #(CLK_PERIOD * TIMEOUT_CYCLES);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
